// File: rtl/ttldf_pkg.sv
// Shared types and constants for the TTL duplicate request filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ttldf_pkg;

   // Field widths
   localparam int unsigned SRC_W  = 32;
   localparam int unsigned RID_W  = 64;
   localparam int unsigned TIME_W = 48;
   localparam int unsigned TTL_W  = 32;

   // Defaults
   localparam int unsigned CACHE_ENTRIES_DEFAULT = 64;
   localparam logic [TTL_W-1:0] TTL_RESET = 32'd10000;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // Top level sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_COMPACT,
      ST_UPDATE,
      ST_EVICT,
      ST_INSERT,
      ST_RESPOND
   } ttldf_state_type;

   // Commands to the insertion order ring
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic advance;
   } ttldf_ring_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/ttl_duplicate_request_filter_core.sv
// Top level of the TTL duplicate request filter: slot store and sequencer.
// Depends on ttldf_pkg and ttldf_order_ring.
//
// Usage: a request transfer carries source address, request id and the time
// now_ms. Each request yields exactly one response transfer with rsp_reply:
// 1 for a new request (remembered until now_ms + ttl_ms), 0 for a duplicate
// of a live remembered request. csr_wr_en writes ttl_ms from csr_wr_data.
// Throughput: one request at a time. From acceptance to the response register
// a request takes one pass over the slot memory for expiry and match, then
// one pass over the insertion order ring that drops expired slots, then, for
// a new request, eviction of the oldest entry if the table is full, and insert.
// The response also waits while the previous response is still held in the
// output register.
// Reset: a clearing pass writes every slot invalid, with req_stall high;
// ttl_ms returns to 10000.
// Stall: the response waits in its output register while rsp_stall is high;
// the next request is already accepted, and its response waits behind it.
`default_nettype none

module ttl_duplicate_request_filter_core #(
   parameter int unsigned CACHE_ENTRIES = ttldf_pkg::CACHE_ENTRIES_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire [ttldf_pkg::SRC_W-1:0]   req_source_address,
   input  wire [ttldf_pkg::RID_W-1:0]   req_request_id,
   input  wire [ttldf_pkg::TIME_W-1:0]  req_now_ms,
   // response channel
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic                         rsp_reply,
   // configuration
   input  wire                          csr_wr_en,
   input  wire [ttldf_pkg::TTL_W-1:0]   csr_wr_data
);
   import ttldf_pkg::*;

   localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CACHE_ENTRIES);
   localparam logic [CNT_W-1:0] LAST_SLOT  = CNT_W'(CACHE_ENTRIES - 1);

   typedef struct packed {
      logic              valid;
      logic [SRC_W-1:0]  source;
      logic [RID_W-1:0]  request;
      logic [TIME_W-1:0] expiry;
   } slot_entry_type;

   // Slot memory
   slot_entry_type slot_mem [CACHE_ENTRIES];
   slot_entry_type slot_rdata_ff;
   slot_entry_type slot_wdata;
   logic             slot_we;
   logic [IDX_W-1:0] slot_waddr, slot_raddr;

   // Control registers
   ttldf_state_type  state_ff, state_in;
   logic [TTL_W-1:0] ttl_ff, ttl_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] keep_ff, keep_in;
   logic             match_ff, match_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] free_ff, free_in;
   logic             scan_vld_ff, scan_vld_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             ord_vld_ff, ord_vld_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_slot_ff, chk_slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_reply_ff, rsp_reply_in;

   // Request payload
   logic [SRC_W-1:0]  src_ff;
   logic [RID_W-1:0]  rid_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] exp_ff, exp_in;
   logic [TIME_W:0]   exp_sum;
   logic              accept;

   // Order ring
   ttldf_ring_ctrl_type ring_ctrl;
   logic [IDX_W-1:0]    ring_rd_pos, ring_wr_pos, ring_wr_slot, ring_rd_slot;

   logic expired, survive, same_key;

   ttldf_order_ring #(
      .ENTRIES (CACHE_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ring_ctrl),
      .rd_pos  (ring_rd_pos),
      .wr_pos  (ring_wr_pos),
      .wr_slot (ring_wr_slot),
      .rd_slot (ring_rd_slot)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_reply = rsp_reply_ff;

   // Expiry with saturation
   always_comb begin
      exp_sum = {1'b0, req_now_ms} + {{(TIME_W+1-TTL_W){1'b0}}, ttl_ff};
      exp_in  = exp_sum[TIME_W] ? TIME_MAX : exp_sum[TIME_W-1:0];
   end

   // Scan stage compare
   always_comb begin
      expired  = slot_rdata_ff.valid && (slot_rdata_ff.expiry <= now_ff);
      survive  = slot_rdata_ff.valid && !expired;
      same_key = (slot_rdata_ff.source == src_ff) && (slot_rdata_ff.request == rid_ff);
   end

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      ttl_in       = csr_wr_en ? csr_wr_data : ttl_ff;
      live_in      = live_ff;
      cnt_in       = cnt_ff;
      keep_in      = keep_ff;
      match_in     = match_ff;
      found_in     = found_ff;
      free_in      = free_ff;
      scan_vld_in  = 1'b0;
      scan_idx_in  = cnt_ff[IDX_W-1:0];
      ord_vld_in   = 1'b0;
      chk_vld_in   = 1'b0;
      chk_slot_in  = ring_rd_slot;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_reply_in = rsp_reply_ff;

      slot_we      = 1'b0;
      slot_waddr   = cnt_ff[IDX_W-1:0];
      slot_wdata   = '0;
      slot_raddr   = cnt_ff[IDX_W-1:0];

      ring_ctrl    = '0;
      ring_rd_pos  = cnt_ff[IDX_W-1:0];
      ring_wr_pos  = keep_ff[IDX_W-1:0];
      ring_wr_slot = chk_slot_ff;

      case (state_ff)
         // write every slot invalid after reset
         ST_CLEAR: begin
            slot_we = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == LAST_SLOT) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               cnt_in   = '0;
               match_in = 1'b0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end

         // expiry, match and first free slot, one slot a cycle
         ST_SCAN: begin
            if (cnt_ff < FULL_COUNT) begin
               scan_vld_in = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end
            if (scan_vld_ff) begin
               if (expired) begin
                  slot_we          = 1'b1;
                  slot_waddr       = scan_idx_ff;
                  slot_wdata       = slot_rdata_ff;
                  slot_wdata.valid = 1'b0;
               end
               if (survive && same_key) begin
                  match_in = 1'b1;
               end
               if (!survive && !found_ff) begin
                  found_in = 1'b1;
                  free_in  = scan_idx_ff;
               end
            end
            if ((cnt_ff == FULL_COUNT) && !scan_vld_ff) begin
               cnt_in   = '0;
               keep_in  = '0;
               state_in = ST_COMPACT;
            end
         end

         // walk the ring oldest first and keep slots still valid
         ST_COMPACT: begin
            if (cnt_ff < live_ff) begin
               ring_ctrl.rd_en = 1'b1;
               ord_vld_in      = 1'b1;
               cnt_in          = cnt_ff + 1'b1;
            end
            if (ord_vld_ff) begin
               slot_raddr = ring_rd_slot;
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff && slot_rdata_ff.valid) begin
               ring_ctrl.wr_en = 1'b1;
               keep_in         = keep_ff + 1'b1;
            end
            if ((cnt_ff == live_ff) && !ord_vld_ff && !chk_vld_ff) begin
               live_in  = keep_ff;
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            if (match_ff) begin
               state_in = ST_RESPOND;
            end else if (live_ff == FULL_COUNT) begin
               ring_ctrl.rd_en = 1'b1;
               ring_rd_pos     = '0;
               state_in        = ST_EVICT;
            end else begin
               state_in = ST_INSERT;
            end
         end

         // oldest slot becomes the free one
         ST_EVICT: begin
            free_in           = ring_rd_slot;
            ring_ctrl.advance = 1'b1;
            live_in           = live_ff - 1'b1;
            state_in          = ST_INSERT;
         end

         ST_INSERT: begin
            slot_we            = 1'b1;
            slot_waddr         = free_ff;
            slot_wdata.valid   = 1'b1;
            slot_wdata.source  = src_ff;
            slot_wdata.request = rid_ff;
            slot_wdata.expiry  = exp_ff;
            ring_ctrl.wr_en    = 1'b1;
            ring_wr_pos        = live_ff[IDX_W-1:0];
            ring_wr_slot       = free_ff;
            live_in            = live_ff + 1'b1;
            state_in           = ST_RESPOND;
         end

         ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_reply_in = !match_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ttl_ff       <= TTL_RESET;
         live_ff      <= '0;
         cnt_ff       <= '0;
         keep_ff      <= '0;
         match_ff     <= 1'b0;
         found_ff     <= 1'b0;
         scan_vld_ff  <= 1'b0;
         ord_vld_ff   <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ttl_ff       <= ttl_in;
         live_ff      <= live_in;
         cnt_ff       <= cnt_in;
         keep_ff      <= keep_in;
         match_ff     <= match_in;
         found_ff     <= found_in;
         scan_vld_ff  <= scan_vld_in;
         ord_vld_ff   <= ord_vld_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff <= req_source_address;
         rid_ff <= req_request_id;
         now_ff <= req_now_ms;
         exp_ff <= exp_in;
      end
      free_ff      <= free_in;
      scan_idx_ff  <= scan_idx_in;
      chk_slot_ff  <= chk_slot_in;
      rsp_reply_ff <= rsp_reply_in;
   end

   // Slot memory, registered read
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rdata_ff <= slot_mem[slot_raddr];
   end

endmodule

`default_nettype wire

// File: rtl/ttldf_order_ring.sv
// Insertion order ring: slot numbers of live entries, oldest at the head.
// Positions are relative to the head. Depends on ttldf_pkg.
`default_nettype none

module ttldf_order_ring #(
   parameter int unsigned ENTRIES = ttldf_pkg::CACHE_ENTRIES_DEFAULT,
   parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire ttldf_pkg::ttldf_ring_ctrl_type ctrl,
   input  wire [IDX_W-1:0]                rd_pos,
   input  wire [IDX_W-1:0]                wr_pos,
   input  wire [IDX_W-1:0]                wr_slot,
   output logic [IDX_W-1:0]               rd_slot
);
   import ttldf_pkg::*;

   localparam logic [IDX_W:0]   ENTRIES_W = (IDX_W+1)'(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_POS  = IDX_W'(ENTRIES - 1);

   logic [IDX_W-1:0] ord_mem [ENTRIES];
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] rd_slot_ff;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [IDX_W:0]   rd_sum, wr_sum;

   // Relative position to physical address, wrapping once
   always_comb begin
      rd_sum = {1'b0, head_ff} + {1'b0, rd_pos};
      wr_sum = {1'b0, head_ff} + {1'b0, wr_pos};
      if (rd_sum >= ENTRIES_W) begin
         rd_sum = rd_sum - ENTRIES_W;
      end
      if (wr_sum >= ENTRIES_W) begin
         wr_sum = wr_sum - ENTRIES_W;
      end
      rd_addr = rd_sum[IDX_W-1:0];
      wr_addr = wr_sum[IDX_W-1:0];
   end

   // Head moves past the evicted oldest entry
   always_comb begin
      head_in = head_ff;
      if (ctrl.advance) begin
         head_in = (head_ff == LAST_POS) ? '0 : head_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   // Order memory, registered read
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         ord_mem[wr_addr] <= wr_slot;
      end
      if (ctrl.rd_en) begin
         rd_slot_ff <= ord_mem[rd_addr];
      end
   end

   assign rd_slot = rd_slot_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for ttl_duplicate_request_filter_core: a directed table, then random request
// streams under several idle/stall mixes, checked transfer by transfer against a predictor.
// Depends on ttldf_pkg and the RTL of the filter core.
`timescale 1ns / 1ps

module tb;
   import ttldf_pkg::*;

   localparam int CLK_HALF_NS   = 6;
   localparam int LIMIT_CYCLES  = 2_000_000;
   localparam int CACHE_ENTRIES = CACHE_ENTRIES_DEFAULT;
   localparam int SEGMENTS      = 8;
   localparam int SEGMENT_ITEMS = 160;
   localparam int RECENT_DEPTH  = 96;

   // How a directed row is checked
   typedef enum logic [1:0] {CHECK_MODEL, WANT_DUPLICATE, WANT_NEW} check_type;
   typedef enum logic {ROW_REQUEST, ROW_SET_TTL} row_kind_type;

   // Set-ttl rows carry the new lifetime in src
   typedef struct {
      row_kind_type       kind;
      logic [SRC_W-1:0]   src;
      logic [RID_W-1:0]   rid;
      logic [TIME_W-1:0]  now;
      check_type          check;
   } stim_row_type;

   typedef struct packed {
      logic [SRC_W-1:0] src;
      logic [RID_W-1:0] rid;
   } request_key_type;

   typedef struct packed {
      request_key_type   key;
      logic [TIME_W-1:0] expiry;
   } remembered_type;

   localparam int DIRECTED_ROWS = 17;
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // fresh after reset, then expiry boundary at exactly now + ttl
      '{ROW_REQUEST, 32'h0, 64'h0, 48'd0,     WANT_NEW},
      '{ROW_REQUEST, 32'h0, 64'h0, 48'd9999,  WANT_DUPLICATE},
      '{ROW_REQUEST, 32'h0, 64'h0, 48'd10000, WANT_NEW},
      // all-ones fields, and keys that differ in one field only
      '{ROW_REQUEST, '1, '1, 48'd10000, WANT_NEW},
      '{ROW_REQUEST, '1, '1, 48'd19999, WANT_DUPLICATE},
      '{ROW_REQUEST, '1, 64'h0, 48'd10001, WANT_NEW},
      '{ROW_REQUEST, 32'h0, '1, 48'd10002, WANT_NEW},
      // time going backwards keeps the entry live
      '{ROW_REQUEST, 32'h0, 64'h0, 48'd5, WANT_DUPLICATE},
      '{ROW_SET_TTL, 32'hFFFF_FFFF, 64'h0, 48'd0, CHECK_MODEL},
      // expiry lands exactly on the time maximum, then saturates
      '{ROW_REQUEST, 32'h1234_5678, 64'h0123_4567_89AB_CDEF, 48'hFFFF_0000_0000, CHECK_MODEL},
      '{ROW_REQUEST, 32'h8765_4321, 64'hFEDC_BA98_7654_3210, 48'hFFFF_FFFF_FFFA, WANT_NEW},
      '{ROW_REQUEST, 32'h8765_4321, 64'hFEDC_BA98_7654_3210, 48'hFFFF_FFFF_FFFE,
        WANT_DUPLICATE},
      '{ROW_REQUEST, 32'h8765_4321, 64'hFEDC_BA98_7654_3210, TIME_MAX, WANT_NEW},
      // zero lifetime: stored already expired
      '{ROW_SET_TTL, 32'h0, 64'h0, 48'd0, CHECK_MODEL},
      '{ROW_REQUEST, 32'h1, 64'h1, 48'd100, CHECK_MODEL},
      '{ROW_REQUEST, 32'h1, 64'h1, 48'd100, WANT_NEW},
      '{ROW_REQUEST, 32'h8765_4321, 64'hFEDC_BA98_7654_3210, 48'd0, CHECK_MODEL}
   };

   logic [TTL_W-1:0] ttl_plan [SEGMENTS] = '{
      32'hFFFF_FFFF, 32'd0, TTL_RESET, 32'd50, 32'd2000, 32'd1, 32'd300, 32'd0
   };

   // DUT ports
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [SRC_W-1:0]  req_source_address = '0;
   logic [RID_W-1:0]  req_request_id = '0;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_reply;
   logic              csr_wr_en = 1'b0;
   logic [TTL_W-1:0]  csr_wr_data = '0;

   // Predictor state and checking
   check_type         row_check = CHECK_MODEL;
   remembered_type    remembered[$];
   logic [TTL_W-1:0]  ttl_model = TTL_RESET;
   bit                pending_replies[$];
   int                mismatch_count = 0;
   int                gap_pct = 0;
   int                stall_pct = 0;

   ttl_duplicate_request_filter_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_source_address (req_source_address),
      .req_request_id     (req_request_id),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_reply          (rsp_reply),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #(CLK_HALF_NS) clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Forget expired entries, look for a live duplicate, else evict oldest if full and remember
   function automatic bit predict_reply(input logic [SRC_W-1:0] src,
                                        input logic [RID_W-1:0] rid,
                                        input logic [TIME_W-1:0] now);
      remembered_type  live[$];
      remembered_type  entry;
      logic [TIME_W:0] sum;
      foreach (remembered[i])
         if (remembered[i].expiry > now) live = {live, remembered[i]};
      remembered = live;
      foreach (remembered[i])
         if (remembered[i].key.src == src && remembered[i].key.rid == rid) return 1'b0;
      if (remembered.size() >= CACHE_ENTRIES) void'(remembered.pop_front());
      sum = {1'b0, now} + {{(TIME_W + 1 - TTL_W){1'b0}}, ttl_model};
      entry.key.src = src;
      entry.key.rid = rid;
      entry.expiry  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      remembered = {remembered, entry};
      return 1'b1;
   endfunction

   // Predict on each request transfer, compare on each response transfer
   always @(posedge clock) begin
      bit answer;
      bit wanted;
      if (reset) begin
         remembered.delete();
         pending_replies.delete();
         ttl_model = TTL_RESET;
      end else begin
         if (csr_wr_en) ttl_model = csr_wr_data;
         if (req_valid && !req_stall) begin
            answer = predict_reply(req_source_address, req_request_id, req_now_ms);
            if (row_check != CHECK_MODEL) answer = (row_check == WANT_NEW);
            pending_replies = {pending_replies, answer};
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("response transfer with no request waiting");
            end else begin
               wanted = pending_replies.pop_front();
               if (rsp_reply !== wanted)
                  report_mismatch($sformatf("reply %b, expected %b", rsp_reply, wanted));
            end
         end
      end
   end

   // Receiver stall pattern
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Leaves req_valid high after the transfer; the next call lowers it only for a gap
   task automatic send_request(input logic [SRC_W-1:0] src, input logic [RID_W-1:0] rid,
                               input logic [TIME_W-1:0] now, input check_type check);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_source_address <= src;
      req_request_id     <= rid;
      req_now_ms         <= now;
      row_check          <= check;
      do @(posedge clock); while (req_stall);
   endtask

   // Lifetime writes only once every response is back
   task automatic write_ttl(input logic [TTL_W-1:0] value);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_replies.size() != 0);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Stimulus
   initial begin
      request_key_type   key;
      request_key_type   recent[$];
      logic [TIME_W-1:0] sim_ms;
      int                roll;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_SET_TTL) write_ttl(directed_rows[i].src);
         else send_request(directed_rows[i].src, directed_rows[i].rid,
                           directed_rows[i].now, directed_rows[i].check);
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         // idle mixes: none, sender gaps, receiver stalls, both light
         case (seg / 2)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 56; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 56; end
            default: begin gap_pct = 11; stall_pct = 11; end
         endcase
         write_ttl((seg == SEGMENTS - 1) ? TTL_W'($urandom) : ttl_plan[seg]);
         sim_ms = $urandom_range(1) ? TIME_MAX - TIME_W'($urandom_range(50000))
                                    : TIME_W'($urandom);
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            // repeats of recent keys, near collisions, and fresh keys
            roll = $urandom_range(99);
            if (roll < 45 && recent.size() != 0) begin
               key = recent[$urandom_range(recent.size() - 1)];
            end else if (roll < 55) begin
               key.src = SRC_W'($urandom_range(3));
               key.rid = RID_W'($urandom_range(3));
            end else begin
               key.src = $urandom;
               key.rid = {$urandom, $urandom};
            end
            // time mostly creeps forward, sometimes jumps or goes back
            roll = $urandom_range(99);
            if (roll < 60)      sim_ms += TIME_W'($urandom_range(3));
            else if (roll < 90) sim_ms += TIME_W'($urandom_range(500));
            else if (roll < 96) sim_ms += TIME_W'($urandom_range(20000));
            else if (roll < 98) sim_ms -= TIME_W'($urandom_range(1000));
            else                sim_ms = TIME_W'({$urandom, $urandom});
            send_request(key.src, key.rid, sim_ms, CHECK_MODEL);
            recent = {recent, key};
            if (recent.size() > RECENT_DEPTH) void'(recent.pop_front());
         end
      end

      // drain, then give the block time to show any stray response
      req_valid <= 1'b0;
      gap_pct   = 0;
      stall_pct = 0;
      do @(negedge clock); while (pending_replies.size() != 0);
      repeat (2 * CACHE_ENTRIES + 40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_CYCLES * 2 * CLK_HALF_NS);
      $display("Verification failed");
      $finish;
   end

endmodule
